@@ hdl/assert_macros.svh @@
// Assertion helpers for the RTL, included by svg_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that prop holds at every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/svg_pkg.sv @@
// ----------------------------------------------------------------------------
// svg_pkg
// Shared types, constants and tables for the star vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none
package svg_pkg;

   localparam int MAX_POINTS_DEF = 31;
   localparam int ANGLE_BITS_DEF = 16;
   localparam int CORDIC_STEPS   = 30;
   localparam int STEP_BITS      = 5;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTER,
      ST_PHASE,
      ST_ROTATE,
      ST_SCALE,
      ST_EMIT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // latch request
      logic center;    // emit centre vertex
      logic div_start; // begin phase division
      logic rot_start; // begin rotation
      logic rot_step;  // one rotation step
      logic scale;     // multiply and round
      logic out_load;  // load output register
      logic advance;   // next rim vertex
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_done;
      logic rot_done;
      logic rim_last;
   } status_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_BITS-1:0] k);
      logic [31:0] v;
      case (k)
         5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051D;
         5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
         5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
         5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
         5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2E;
         5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9; 5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F; 5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B; 5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2; 5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000028; 5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000002; 5'd29: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hdl/star_vertex_generator.sv @@
// ----------------------------------------------------------------------------
// star_vertex_generator
// Emits a triangle-fan star of 2np+2 vertices for each request.
// ----------------------------------------------------------------------------
// A request is taken only while idle and yields 2np+2 vertex words; the last
// carries tlast. The centre word is loaded once the output register is free
// after the accept. Each rim vertex then passes through the bit-serial phase
// division, 30 steps of one shared CORDIC rotator, one scaling step and one
// output load, which waits until the output register is free. A single
// output register decouples the result side.
`default_nettype none
module star_vertex_generator
   import svg_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,  // outer_radius[14:0], point_count[19:15], height[35:20]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [87:0]      rsp_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number
   output logic             rsp_tlast
);

   cmd_type     cmd;
   status_type  status;
   logic        out_free;
   logic [86:0] word;

   svg_ctrl u_ctrl (
      .clock, .reset,
      .req_fire (req_tvalid && req_tready),
      .out_free, .status, .req_ready(req_tready), .cmd
   );

   svg_datapath #(.MAX_POINTS(MAX_POINTS), .ANGLE_BITS(ANGLE_BITS)) u_dp (
      .clock, .reset, .cmd,
      .req_radius (req_tdata[14:0]),
      .req_points (req_tdata[19:15]),
      .req_height (req_tdata[35:20]),
      .out_take   (rsp_tvalid && rsp_tready),
      .status, .out_free,
      .out_valid  (rsp_tvalid),
      .out_word   (word)
   );

   assign rsp_tdata = {2'b00, word[85:0]};
   assign rsp_tlast = word[86];

endmodule
`default_nettype wire

@@ hdl/svg_ctrl.sv @@
// ----------------------------------------------------------------------------
// svg_ctrl
// Sequencer: request latch, phase division, rotation steps, scaling, output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module svg_ctrl
   import svg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_fire,
   input  wire logic       out_free,
   input  wire status_type status,
   output logic            req_ready,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load = 1'b1;
               state_in = ST_CENTER;
            end
         end
         ST_CENTER: begin
            if (out_free) begin
               cmd.center    = 1'b1;
               cmd.out_load  = 1'b1;
               cmd.div_start = 1'b1;
               state_in      = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (status.div_done) begin
               cmd.rot_start = 1'b1;
               state_in      = ST_ROTATE;
            end
         end
         ST_ROTATE: begin
            cmd.rot_step = 1'b1;
            if (status.rot_done) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               if (status.rim_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance   = 1'b1;
                  cmd.div_start = 1'b1;
                  state_in      = ST_PHASE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_CLK(a_load_idle, clock, reset, cmd.load |-> state_ff == ST_IDLE, "load outside idle")
   `ASSERT_CLK(a_ready_idle, clock, reset, req_ready == (state_ff == ST_IDLE), "ready mismatch")
   `ASSERT_CLK(a_out_free, clock, reset, cmd.out_load |-> out_free, "output overrun")

endmodule
`default_nettype wire

@@ hdl/svg_datapath.sv @@
// ----------------------------------------------------------------------------
// svg_datapath
// Held request, restoring phase divider, shared CORDIC step, scaling, output.
// ----------------------------------------------------------------------------
`default_nettype none
module svg_datapath
   import svg_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic [14:0] req_radius,
   input  wire logic [4:0]  req_points,
   input  wire logic [15:0] req_height,
   input  wire logic        out_take,
   output status_type       status,
   output logic             out_free,
   output logic             out_valid,
   output logic [86:0]      out_word
);

   localparam int NUM_W = ANGLE_BITS + 7;   // i*2^A + np
   localparam int DIV_CNT_W = $clog2(NUM_W + 1);
   localparam logic [4:0] MAX_NP = 5'(MAX_POINTS);

   logic [14:0] radius_ff;
   logic [15:0] height_ff;
   logic [4:0]  np_ff;
   logic [5:0]  rim_ff;       // rim index i
   logic [5:0]  vnum_ff;

   // divider
   logic [NUM_W-1:0]     quo_ff;
   logic [6:0]           rem_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic                 div_busy_ff;

   // rotation
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic [STEP_BITS-1:0] k_ff;
   logic flip_ff;

   logic signed [15:0] px_ff, py_ff;
   logic [15:0] tu_ff, tv_ff;

   logic [86:0] out_ff;
   logic        out_valid_ff;

   logic [5:0]  n2;
   logic [4:0]  np_sat;
   always_comb begin
      np_sat = (req_points == 5'd0) ? 5'd1 : req_points;
      if (np_sat > MAX_NP) np_sat = MAX_NP;
   end
   assign n2 = {np_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         radius_ff <= req_radius;
         height_ff <= req_height;
         np_ff     <= np_sat;
      end
      if (cmd.center) begin
         rim_ff  <= 6'd0;
         vnum_ff <= 6'd1;
      end else if (cmd.advance) begin
         rim_ff  <= rim_ff + 6'd1;
         vnum_ff <= vnum_ff + 6'd1;
      end
   end

   // restoring division of (i*2^A + np) by 2np, one bit a cycle;
   // numer belongs to the rim vertex that follows the current one
   logic [NUM_W-1:0] numer;
   logic [7:0]       trial;
   assign numer = (NUM_W'(rim_ff + 6'd1) << ANGLE_BITS) + NUM_W'(np_ff);
   assign trial = {rem_ff, quo_ff[NUM_W-1]} - {2'b00, n2};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (div_busy_ff && div_cnt_ff == DIV_CNT_W'(NUM_W - 1)) begin
         div_busy_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         quo_ff     <= cmd.center ? NUM_W'(np_ff) : numer;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (!trial[7]) begin
            rem_ff <= trial[6:0];
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[5:0], quo_ff[NUM_W-1]};
            quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
         end
      end
   end
   assign status.div_done = !div_busy_ff;

   // phase and fold
   logic [ANGLE_BITS-1:0] phase;
   logic [31:0] phase32, folded;
   logic q_flip;
   assign phase   = ANGLE_BITS'(1 << (ANGLE_BITS - 2)) + quo_ff[ANGLE_BITS-1:0];
   assign phase32 = {phase, {(32-ANGLE_BITS){1'b0}}};
   assign q_flip  = phase32[31] ^ phase32[30];
   assign folded  = q_flip ? phase32 - 32'h80000000 : phase32;

   logic signed [33:0] dx, dy, at;
   assign dx = y_ff >>> k_ff;
   assign dy = x_ff >>> k_ff;
   assign at = 34'(atan_entry(k_ff));

   always_ff @(posedge clock) begin
      if (cmd.rot_start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= 34'(signed'(folded));
         k_ff    <= '0;
         flip_ff <= q_flip;
      end else if (cmd.rot_step) begin
         if (!z_ff[33]) begin
            x_ff <= x_ff - dx; y_ff <= y_ff + dy; z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + dx; y_ff <= y_ff - dy; z_ff <= z_ff + at;
         end
         k_ff <= k_ff + 1'b1;
      end
   end
   assign status.rot_done = (k_ff == STEP_BITS'(CORDIC_STEPS - 1));
   assign status.rim_last = (rim_ff == n2);

   // scaling: one 15x34 multiply per axis
   logic signed [33:0] c, s;
   logic odd;
   logic signed [49:0] mx, my;
   logic signed [49:0] rx, ry;
   logic signed [33:0] tcu, tcv;
   assign c   = flip_ff ? -x_ff : x_ff;
   assign s   = flip_ff ? -y_ff : y_ff;
   assign odd = rim_ff[0];
   assign mx  = $signed({1'b0, radius_ff}) * c;
   assign my  = $signed({1'b0, radius_ff}) * s;
   assign rx  = odd ? (mx + 50'sd1073741824) >>> 31 : (mx + 50'sd536870912) >>> 30;
   assign ry  = odd ? (my + 50'sd1073741824) >>> 31 : (my + 50'sd536870912) >>> 30;
   assign tcu = 34'sd16384 + (odd ? (c + 34'sd65536) >>> 17 : (c + 34'sd32768) >>> 16);
   assign tcv = 34'sd16384 + (odd ? (s + 34'sd65536) >>> 17 : (s + 34'sd32768) >>> 16);

   function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
      if (v > 50'sd32767) return 16'sh7FFF;
      if (v < -50'sd32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic logic [15:0] satt(input logic signed [33:0] v);
      if (v < 34'sd0) return 16'd0;
      if (v > 34'sd32768) return 16'd32768;
      return v[15:0];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         px_ff <= sat16(rx);
         py_ff <= sat16(ry);
         tu_ff <= satt(tcu);
         tv_ff <= satt(tcv);
      end
   end

   // output register: x,y,z,u,v,num,last
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         if (cmd.center) begin
            out_ff <= {1'b0, 6'd0, 16'd16384, 16'd16384, 16'd0, 16'd0, 16'd0};
         end else begin
            out_ff <= {status.rim_last, vnum_ff, tv_ff, tu_ff, height_ff, py_ff, px_ff};
         end
      end
   end

   assign out_free  = !out_valid_ff || out_take;
   assign out_valid = out_valid_ff;
   assign out_word  = out_ff;

endmodule
`default_nettype wire

@@ test/star_vertex_generator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// star_vertex_generator_tb
// Drives star requests in bursts while the vertex side stalls on its own
// pattern, and compares every vertex word with a CORDIC-based predictor.
// ----------------------------------------------------------------------------
module star_vertex_generator_tb;
   import svg_pkg::*;

   localparam int    NUM_RANDOM   = 180;
   localparam int    IDLE_LIMIT   = 20000;
   localparam int    DRAIN_CYCLES = 200;
   localparam int    LONG_HOLD    = 3000;
   localparam int    FULL_TURN    = 65536;
   localparam longint ARC_TURN [CORDIC_STEPS] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051, 64'h00000028,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000002, 64'h00000001};

   typedef struct packed {
      logic [5:0]         num;
      logic [15:0]        tv;
      logic [15:0]        tu;
      logic signed [15:0] pz;
      logic signed [15:0] py;
      logic signed [15:0] px;
   } vertex_type;

   class star_scoreboard;
      vertex_type vertex_queue[$];
      bit         last_queue[$];
      int         requests;
      int         vertices;

      function longint round_shift(longint v, int k);
         return (v + (longint'(1) << (k - 1))) >>> k;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function void rotate(input logic [31:0] phase, output longint c, output longint s);
         bit     flip;
         longint x, y, z, dx, dy;
         flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
         if (flip)
            phase = phase - 32'h80000000;
         z = longint'($signed(phase));
         x = longint'(CORDIC_GAIN);
         y = 0;
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ARC_TURN[k];
            end else begin
               x += dx; y -= dy; z += ARC_TURN[k];
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      // expand one request into its whole fan of vertices
      function void note_request(logic [39:0] word);
         longint     radius, np, n2, step, phase, c, s;
         int         pshift, tshift;
         vertex_type v;
         radius = word[14:0];
         np     = word[19:15];
         if (np == 0)
            np = 1;
         if (np > MAX_POINTS_DEF)
            np = MAX_POINTS_DEF;
         n2 = 2 * np;
         requests++;
         v = '{num: 6'd0, tv: 16'd16384, tu: 16'd16384, pz: 16'sd0, py: 16'sd0, px: 16'sd0};
         vertex_queue = {vertex_queue, v};
         last_queue   = {last_queue, 1'b0};
         for (longint i = 0; i <= n2; i++) begin
            step   = (i * FULL_TURN + np) / n2;
            phase  = (FULL_TURN / 4 + step) & (FULL_TURN - 1);
            pshift = i[0] ? 31 : 30;
            tshift = i[0] ? 17 : 16;
            rotate(32'(phase << 16), c, s);
            v.px  = 16'(clamp(round_shift(radius * c, pshift), -32768, 32767));
            v.py  = 16'(clamp(round_shift(radius * s, pshift), -32768, 32767));
            v.pz  = word[35:20];
            v.tu  = 16'(clamp(16384 + round_shift(c, tshift), 0, 32768));
            v.tv  = 16'(clamp(16384 + round_shift(s, tshift), 0, 32768));
            v.num = 6'(i + 1);
            vertex_queue = {vertex_queue, v};
            last_queue   = {last_queue, (i == n2)};
         end
      endfunction

      // returns the names of the wrong fields, empty when the word matches
      function string check_vertex(logic [87:0] word, logic last);
         vertex_type got, want;
         bit         want_last;
         string      bad;
         bad = "";
         if (vertex_queue.size() == 0)
            return "unexpected word";
         got       = word[85:0];
         want      = vertex_queue.pop_front();
         want_last = last_queue.pop_front();
         vertices++;
         if (got.px !== want.px)   bad = {bad, $sformatf(" pos_x %0d/%0d", got.px, want.px)};
         if (got.py !== want.py)   bad = {bad, $sformatf(" pos_y %0d/%0d", got.py, want.py)};
         if (got.pz !== want.pz)   bad = {bad, $sformatf(" pos_z %0d/%0d", got.pz, want.pz)};
         if (got.tu !== want.tu)   bad = {bad, $sformatf(" tex_u %0d/%0d", got.tu, want.tu)};
         if (got.tv !== want.tv)   bad = {bad, $sformatf(" tex_v %0d/%0d", got.tv, want.tv)};
         if (got.num !== want.num) bad = {bad, $sformatf(" vertex %0d/%0d", got.num, want.num)};
         if (last !== want_last)   bad = {bad, $sformatf(" last %0b/%0b", last, want_last)};
         return bad;
      endfunction

      function int pending();
         return vertex_queue.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // outer_radius[14:0], point_count[19:15], height[35:20]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [87:0] rsp_tdata;   // pos_x, pos_y, pos_z, tex_u, tex_v, vertex_number
   logic        rsp_tlast;

   star_scoreboard fan_board;
   int             error_count;
   int             idle_cycles;
   bit             hold_request;
   bit             holding;

   star_vertex_generator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   task automatic report(string what);
      error_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // monitor both channels and the idle watchdog
   always @(posedge clock) begin
      string bad;
      bit    moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            fan_board.note_request(req_tdata);
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            bad = fan_board.check_vertex(rsp_tdata, rsp_tlast);
            if (bad != "")
               report(bad);
            moved = 1'b1;
         end
         if (moved)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // receiver: a long hold on request, otherwise a pattern that changes mode
   always @(negedge clock) begin
      int phase_cycle;
      int mode;
      int hold_left;
      if (reset) begin
         rsp_tready  = 1'b0;
         phase_cycle = 0;
         mode        = 0;
         hold_left   = 0;
      end else if (hold_request && !holding) begin
         holding    = 1'b1;
         hold_left  = LONG_HOLD;
         rsp_tready = 1'b0;
      end else if (holding) begin
         hold_left--;
         if (hold_left == 0) begin
            holding      = 1'b0;
            hold_request = 1'b0;
         end
      end else begin
         phase_cycle++;
         if (phase_cycle % 400 == 0)
            mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = $urandom_range(0, 1);
            2: rsp_tready = (phase_cycle % 5 == 0);
            default: rsp_tready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   int burst_left;

   // offer one request word and hold it until taken
   task automatic send_request(logic [14:0] radius, logic [4:0] points, logic [15:0] height);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 40)) @(negedge clock);
         burst_left = $urandom_range(1, 6);
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tdata  = {4'd0, height, points, radius};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic send_random();
      logic [4:0] points;
      points = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 6));
      send_request(15'($urandom), points, 16'($urandom));
   endtask

   initial begin
      fan_board    = new();
      error_count  = 0;
      idle_cycles  = 0;
      hold_request = 1'b0;
      holding      = 1'b0;
      burst_left   = 0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // extremes, zero and full point count
      send_request(15'd0,     5'd0,  16'h0000);
      send_request(15'h7FFF,  5'd1,  16'h7FFF);
      send_request(15'h7FFF,  5'd31, 16'h8000);
      send_request(15'd256,   5'd2,  16'hFFFF);
      send_request(15'h7FFF,  5'd0,  16'h0001);
      send_request(15'd1,     5'd3,  16'h0100);
      send_request(15'd3,     5'd31, 16'h5555);
      send_request(15'h5555,  5'd21, 16'hAAAA);
      send_request(15'h2AAA,  5'd10, 16'h1234);
      send_request(15'h4000,  5'd4,  16'hC000);
      send_request(15'h7FFF,  5'd5,  16'h0000);
      send_request(15'd2,     5'd6,  16'h7FFE);

      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == 40)
            hold_request = 1'b1;
         if (n == 120)
            while (fan_board.pending() != 0) @(negedge clock);
         send_random();
      end

      while (fan_board.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d star requests and %0d vertex words", fan_board.requests,
               fan_board.vertices);
      $display("Point counts 0..31, radius and height extremes, long output stall");
      if (error_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
